### src/assert_macros.svh
// Assertion macros for the RTL files.
// Depends on nothing; included by modules that carry concurrent checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// check a property on every clock edge outside reset (active-low reset)
`define ASSERT_SYNC(label, clk, rst_n, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// check a property on every clock edge, reset included
`define ASSERT_ALWAYS(label, clk, prop, msg) \
    label: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

### src/sstab_pkg.sv
// Package for the sorted sparse index/value table: parameter defaults,
// action and status codes, and the result item type. Depends on nothing.
package sstab_pkg;

    localparam int CAPACITY_DEF   = 128;
    localparam int INDEX_BITS_DEF = 10;

    localparam int ACTION_W = 2;
    localparam int KEY_W    = 10;
    localparam int VALUE_W  = 64;
    localparam int RPOS_W   = 7;
    localparam int STATUS_W = 2;
    localparam int OPOS_W   = 8;
    localparam int OCNT_W   = 8;

    typedef enum logic [ACTION_W-1:0] {
        ACT_LOOKUP = 2'd0,
        ACT_WRITE  = 2'd1,
        ACT_READ   = 2'd2,
        ACT_NONE   = 2'd3
    } t_action;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_MISS  = 2'd1,
        ST_FULL  = 2'd2,
        ST_RANGE = 2'd3
    } t_status;

    typedef struct packed {
        t_status             status;
        logic [OPOS_W-1:0]   position;
        logic [KEY_W-1:0]    index;
        logic [VALUE_W-1:0]  value;
    } t_result;

endpackage

### src/sorted_sparse_index_value_table.sv
// Sorted sparse index/value table: top level with the entry memory.
// Depends on sstab_pkg and assert_macros.svh.
//
// Usage:
//   Input channel  (i_in_valid / o_in_stall) carries one action item:
//   lookup by index, write or insert by index, or read by position.
//   Output channel (o_out_valid / i_out_stall) returns one result item per
//   input item, in order. An item moves when valid is high and stall is low.
//   Entries sit sorted in one memory (index and value side by side) with a
//   registered read. Lookup and write run a binary search that issues one
//   memory read per cycle until the search window closes.
//   A read by position passes through S_READ to S_OUT; a read past the count
//   or an unused action goes straight to S_OUT.
//   An insert moves the entries at and above its position up by one in S_SHIFT,
//   then writes the new entry in S_PUT; at the end it goes straight to S_PUT. Entries shift one per cycle.
//   One item is in work at a time; o_in_stall is high while it runs.
//   The finished result waits in the output register while the receiver
//   stalls; the next item is taken once that result has been loaded there.
//   Reset (synchronous, active low) empties the table at once; memory
//   contents are left as they are and are never read before being written.
module sorted_sparse_index_value_table #(
    parameter int CAPACITY   = sstab_pkg::CAPACITY_DEF,
    parameter int INDEX_BITS = sstab_pkg::INDEX_BITS_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_in_valid,
    output logic                          o_in_stall,
    input  logic [sstab_pkg::ACTION_W-1:0] i_action,
    input  logic [sstab_pkg::KEY_W-1:0]    i_factor_index,
    input  logic [sstab_pkg::VALUE_W-1:0]  i_write_value,
    input  logic [sstab_pkg::RPOS_W-1:0]   i_read_position,
    output logic                          o_out_valid,
    input  logic                          i_out_stall,
    output logic [sstab_pkg::STATUS_W-1:0] o_status,
    output logic [sstab_pkg::OPOS_W-1:0]   o_entry_position,
    output logic [sstab_pkg::KEY_W-1:0]    o_entry_index,
    output logic [sstab_pkg::VALUE_W-1:0]  o_entry_value,
    output logic [sstab_pkg::OCNT_W-1:0]   o_entry_count
);

    `include "assert_macros.svh"

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int PW = (CW > sstab_pkg::RPOS_W) ? CW : sstab_pkg::RPOS_W;
    localparam int VW = sstab_pkg::VALUE_W;
    localparam int DW = INDEX_BITS + VW;

    typedef enum logic [5:0] {
        S_IDLE   = 6'b000001,
        S_SEARCH = 6'b000010,
        S_SHIFT  = 6'b000100,
        S_PUT    = 6'b001000,
        S_READ   = 6'b010000,
        S_OUT    = 6'b100000
    } t_state;

    logic [DW-1:0] mem [CAPACITY];
    logic [DW-1:0] r_rdata;
    logic [AW-1:0] mem_ra;
    logic          mem_we;
    logic [AW-1:0] mem_wa;
    logic [DW-1:0] mem_wd;

    t_state                    r_state, n_state;
    logic [CW-1:0]             r_count, n_count;
    sstab_pkg::t_action        r_action, n_action;
    logic [INDEX_BITS-1:0]     r_key, n_key;
    logic [VW-1:0]             r_wval, n_wval;
    logic [CW-1:0]             r_lo, n_lo;
    logic [CW-1:0]             r_hi, n_hi;
    logic [CW-1:0]             r_mid, n_mid;
    logic                      r_pend, n_pend;
    logic                      r_hit, n_hit;
    logic [VW-1:0]             r_hit_val, n_hit_val;
    logic [CW-1:0]             r_pos, n_pos;
    logic [CW-1:0]             r_k, n_k;
    sstab_pkg::t_result        r_res, n_res;
    logic                      r_out_valid, n_out_valid;
    sstab_pkg::t_result        r_out, n_out;
    logic [sstab_pkg::OCNT_W-1:0] r_out_count, n_out_count;

    logic [INDEX_BITS-1:0] rd_idx;
    logic [VW-1:0]         rd_val;
    logic [CW-1:0]         lo_c, hi_c, mid_c;
    logic                  hit_c;
    logic [VW-1:0]         hit_val_c;
    logic                  in_accept;
    logic                  out_free;

    assign rd_idx    = r_rdata[DW-1:VW];
    assign rd_val    = r_rdata[VW-1:0];
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_free  = !r_out_valid || !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    always_comb begin
        lo_c      = r_lo;
        hi_c      = r_hi;
        hit_c     = r_hit;
        hit_val_c = r_hit_val;
        if (r_pend) begin
            if (rd_idx < r_key) begin
                lo_c = CW'(r_mid + 1'b1);
            end else begin
                hi_c = r_mid;
            end
            if (rd_idx == r_key) begin
                hit_c     = 1'b1;
                hit_val_c = rd_val;
            end
        end
        mid_c = CW'(lo_c + ((hi_c - lo_c) >> 1));
    end

    always_comb begin
        n_state     = r_state;
        n_count     = r_count;
        n_action    = r_action;
        n_key       = r_key;
        n_wval      = r_wval;
        n_lo        = r_lo;
        n_hi        = r_hi;
        n_mid       = r_mid;
        n_pend      = r_pend;
        n_hit       = r_hit;
        n_hit_val   = r_hit_val;
        n_pos       = r_pos;
        n_k         = r_k;
        n_res       = r_res;
        n_out_valid = r_out_valid;
        n_out       = r_out;
        n_out_count = r_out_count;
        mem_ra      = '0;
        mem_we      = 1'b0;
        mem_wa      = '0;
        mem_wd      = '0;

        if (r_out_valid && !i_out_stall) begin
            n_out_valid = 1'b0;
        end

        unique case (r_state)
            S_IDLE: begin
                mem_ra = AW'(i_read_position);
                if (in_accept) begin
                    n_action  = sstab_pkg::t_action'(i_action);
                    n_key     = INDEX_BITS'(i_factor_index);
                    n_wval    = i_write_value;
                    n_lo      = '0;
                    n_hi      = r_count;
                    n_pend    = 1'b0;
                    n_hit     = 1'b0;
                    n_hit_val = '0;
                    unique case (sstab_pkg::t_action'(i_action))
                        sstab_pkg::ACT_LOOKUP, sstab_pkg::ACT_WRITE: begin
                            n_state = S_SEARCH;
                        end
                        sstab_pkg::ACT_READ: begin
                            n_res.status   = sstab_pkg::ST_RANGE;
                            n_res.position = sstab_pkg::OPOS_W'(i_read_position);
                            n_res.index    = '0;
                            n_res.value    = '0;
                            if (PW'(i_read_position) < PW'(r_count)) begin
                                n_state = S_READ;
                            end else begin
                                n_state = S_OUT;
                            end
                        end
                        default: begin
                            n_res.status   = sstab_pkg::ST_RANGE;
                            n_res.position = '0;
                            n_res.index    = '0;
                            n_res.value    = '0;
                            n_state        = S_OUT;
                        end
                    endcase
                end
            end
            S_SEARCH: begin
                n_lo      = lo_c;
                n_hi      = hi_c;
                n_hit     = hit_c;
                n_hit_val = hit_val_c;
                mem_ra    = AW'(mid_c);
                if (lo_c < hi_c) begin
                    n_mid  = mid_c;
                    n_pend = 1'b1;
                end else begin
                    n_pend         = 1'b0;
                    n_pos          = lo_c;
                    n_res.index    = sstab_pkg::KEY_W'(r_key);
                    n_res.position = sstab_pkg::OPOS_W'(lo_c);
                    if (r_action == sstab_pkg::ACT_LOOKUP) begin
                        if (hit_c) begin
                            n_res.status = sstab_pkg::ST_OK;
                            n_res.value  = hit_val_c;
                        end else begin
                            n_res.status   = sstab_pkg::ST_MISS;
                            n_res.position = sstab_pkg::OPOS_W'(r_count);
                            n_res.value    = '0;
                        end
                        n_state = S_OUT;
                    end else if (hit_c) begin
                        mem_we       = 1'b1;
                        mem_wa       = AW'(lo_c);
                        mem_wd       = {r_key, r_wval};
                        n_res.status = sstab_pkg::ST_OK;
                        n_res.value  = r_wval;
                        n_state      = S_OUT;
                    end else if (r_count == CW'(CAPACITY)) begin
                        n_res.status   = sstab_pkg::ST_FULL;
                        n_res.position = sstab_pkg::OPOS_W'(r_count);
                        n_res.value    = '0;
                        n_state        = S_OUT;
                    end else if (lo_c == r_count) begin
                        n_state = S_PUT;
                    end else begin
                        n_k     = r_count;
                        n_state = S_SHIFT;
                    end
                end
            end
            S_SHIFT: begin
                mem_we = r_pend;
                mem_wa = AW'(r_k + 1'b1);
                mem_wd = r_rdata;
                if (r_k > r_pos) begin
                    mem_ra = AW'(r_k - 1'b1);
                    n_k    = CW'(r_k - 1'b1);
                    n_pend = 1'b1;
                end else begin
                    n_pend  = 1'b0;
                    n_state = S_PUT;
                end
            end
            S_PUT: begin
                mem_we         = 1'b1;
                mem_wa         = AW'(r_pos);
                mem_wd         = {r_key, r_wval};
                n_count        = CW'(r_count + 1'b1);
                n_res.status   = sstab_pkg::ST_OK;
                n_res.position = sstab_pkg::OPOS_W'(r_pos);
                n_res.index    = sstab_pkg::KEY_W'(r_key);
                n_res.value    = r_wval;
                n_state        = S_OUT;
            end
            S_READ: begin
                n_res.status = sstab_pkg::ST_OK;
                n_res.index  = sstab_pkg::KEY_W'(rd_idx);
                n_res.value  = rd_val;
                n_state      = S_OUT;
            end
            S_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out       = r_res;
                    n_out_count = sstab_pkg::OCNT_W'(r_count);
                    n_state     = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_pend      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_count     <= n_count;
            r_pend      <= n_pend;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action    <= n_action;
        r_key       <= n_key;
        r_wval      <= n_wval;
        r_lo        <= n_lo;
        r_hi        <= n_hi;
        r_mid       <= n_mid;
        r_hit       <= n_hit;
        r_hit_val   <= n_hit_val;
        r_pos       <= n_pos;
        r_k         <= n_k;
        r_res       <= n_res;
        r_out       <= n_out;
        r_out_count <= n_out_count;
    end

    assign o_in_stall       = (r_state != S_IDLE);
    assign o_out_valid      = r_out_valid;
    assign o_status         = r_out.status;
    assign o_entry_position = r_out.position;
    assign o_entry_index    = r_out.index;
    assign o_entry_value    = r_out.value;
    assign o_entry_count    = r_out_count;

    `ASSERT_SYNC(a_count_bound, i_clk, i_rst_n,
        r_count <= CW'(CAPACITY), "count above capacity")
    `ASSERT_SYNC(a_search_window, i_clk, i_rst_n,
        (r_state == S_SEARCH) |-> ((r_lo <= r_hi) && (r_hi <= r_count)),
        "search window out of bounds")
    `ASSERT_SYNC(a_count_on_put, i_clk, i_rst_n,
        (r_state != S_PUT) |=> $stable(r_count), "count changed outside insert")

endmodule
